// ===== hdl/msgt_pkg.sv =====
package msgt_pkg;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 4;
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int SEQ_W  = 64;
  localparam int CNT_W  = 16;
  localparam int TS_W   = 48;
  localparam int TOT_W  = 32;
  localparam int ST_W   = 3;
  // wide enough for the largest group table (64 slots)
  localparam int SLOT_W = 6;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_PACKET = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  typedef enum logic [ST_W-1:0] {
    ST_WRITTEN  = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_FIRST    = 3'd2,
    ST_IN_ORDER = 3'd3,
    ST_GAP      = 3'd4,
    ST_BACK     = 3'd5,
    ST_REPORT   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_IGNORE,
    CMD_PACKET,
    CMD_READ
  } cmd_kind_t;

  // classified word handed from front end to back end
  typedef struct packed {
    cmd_kind_t          kind;
    logic [SLOT_W-1:0]  slot;
    logic [SEQ_W-1:0]   seq;
    logic [CNT_W-1:0]   cnt;
    logic [TS_W-1:0]    ts;
  } cmd_t;

  // per-group tracking entry
  typedef struct packed {
    logic [SEQ_W-1:0] exp_seq;
    logic [TS_W-1:0]  ts;
    logic [TOT_W-1:0] gaps;
    logic [TOT_W-1:0] backs;
  } track_t;

endpackage

// ===== hdl/msgt_front.sv =====
module msgt_front import msgt_pkg::*; #(
  parameter int GROUPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic              in_entry_valid,
  input  logic [ADDR_W-1:0] in_dst_address,
  input  logic [PORT_W-1:0] in_dst_port,
  input  logic              in_is_udp,
  input  logic [SEQ_W-1:0]  in_seq_number,
  input  logic [CNT_W-1:0]  in_msg_count,
  input  logic [TS_W-1:0]   in_timestamp_ns,
  output logic              push,
  output cmd_t              push_cmd,
  input  logic              q_full
);

  logic [ADDR_W-1:0] tbl_addr_r [GROUPS];
  logic [PORT_W-1:0] tbl_port_r [GROUPS];
  logic [GROUPS-1:0] tbl_v_r;

  logic              s1_v_r;
  cmd_t              s1_cmd_r;
  logic [GROUPS-1:0] s1_hit_r;

  logic              acc;
  logic              idx_ok;
  cmd_kind_t         kind;
  logic [GROUPS-1:0] hit;
  logic              found;
  logic [SLOT_W-1:0] sel;

  assign in_ready = !s1_v_r;
  assign acc      = in_valid && in_ready;
  assign idx_ok   = 32'(in_entry_index) < GROUPS;

  always_comb begin
    priority if (in_op == OP_WRITE && idx_ok) begin
      kind = CMD_WRITE;
    end else if (in_op == OP_READ && idx_ok) begin
      kind = CMD_READ;
    end else if (in_op == OP_PACKET && in_is_udp) begin
      kind = CMD_PACKET;
    end else begin
      kind = CMD_IGNORE;
    end
  end

  // parallel compare against every slot; address and port must both match
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      hit[g] = tbl_v_r[g] && (tbl_addr_r[g] == in_dst_address) &&
               (tbl_port_r[g] == in_dst_port);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_v_r <= '0;
    end else if (acc && kind == CMD_WRITE) begin
      for (int g = 0; g < GROUPS; g++) begin
        if (32'(in_entry_index) == g) begin
          tbl_v_r[g] <= in_entry_valid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && kind == CMD_WRITE) begin
      for (int g = 0; g < GROUPS; g++) begin
        if (32'(in_entry_index) == g) begin
          tbl_addr_r[g] <= in_dst_address;
          tbl_port_r[g] <= in_dst_port;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (push) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd_r.kind <= kind;
      s1_cmd_r.slot <= (kind == CMD_IGNORE) ? '0 : SLOT_W'(in_entry_index);
      s1_cmd_r.seq  <= in_seq_number;
      s1_cmd_r.cnt  <= in_msg_count;
      s1_cmd_r.ts   <= in_timestamp_ns;
      s1_hit_r      <= hit;
    end
  end

  // lowest matching slot wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (s1_hit_r[g]) begin
        found = 1'b1;
        sel   = SLOT_W'(g);
      end
    end
  end

  always_comb begin
    push_cmd = s1_cmd_r;
    if (s1_cmd_r.kind == CMD_PACKET) begin
      if (found) begin
        push_cmd.slot = sel;
      end else begin
        push_cmd.kind = CMD_IGNORE;
        push_cmd.slot = '0;
      end
    end
  end

  assign push = s1_v_r && !q_full;

endmodule

// ===== hdl/msgt_queue.sv =====
module msgt_queue import msgt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t       slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = slot_r[rp_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue pop while empty");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wp_r != rp_r)) else $error("queue pointers out of step");
`endif

endmodule

// ===== hdl/msgt_back.sv =====
module msgt_back import msgt_pkg::*; #(
  parameter int GROUPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   out_status,
  output logic [IDX_W-1:0]  out_group_index,
  output logic [SEQ_W-1:0]  out_expected_seq,
  output logic [SEQ_W-1:0]  out_lost_count,
  output logic [TS_W-1:0]   out_down_time_ns,
  output logic [TS_W-1:0]   out_prev_timestamp,
  output logic [TOT_W-1:0]  out_gap_total,
  output logic [TOT_W-1:0]  out_back_total
);

  localparam int IW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t            state_r;
  cmd_t              cmd_r;
  track_t            mem [GROUPS];
  track_t            rd_r;
  logic              rd_v_r;
  logic [GROUPS-1:0] trk_v_r;

  logic              out_valid_r;
  status_t           st_r;
  logic [IDX_W-1:0]  gidx_r;
  logic [SEQ_W-1:0]  exp_r;
  logic [SEQ_W-1:0]  lost_r;
  logic [TS_W-1:0]   down_r;
  logic [TS_W-1:0]   prev_r;
  logic [TOT_W-1:0]  gaps_r;
  logic [TOT_W-1:0]  backs_r;

  logic [IW-1:0]     ra;
  logic [IW-1:0]     wa;
  logic              fire;
  track_t            cur;
  track_t            upd;
  status_t           st;
  logic [SEQ_W-1:0]  exp_o;
  logic [SEQ_W-1:0]  lost_o;
  logic [TS_W-1:0]   down_o;
  logic [TS_W-1:0]   prev_o;
  logic [TOT_W-1:0]  gaps_o;
  logic [TOT_W-1:0]  backs_o;

  assign pop  = (state_r == S_IDLE) && !q_empty;
  assign ra   = head.slot[IW-1:0];
  assign wa   = cmd_r.slot[IW-1:0];
  assign fire = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // slot never touched since reset reads as all zero
  assign cur = rd_v_r ? rd_r : '0;

  always_comb begin
    st      = ST_IGNORED;
    exp_o   = '0;
    lost_o  = '0;
    down_o  = '0;
    prev_o  = '0;
    gaps_o  = '0;
    backs_o = '0;
    upd.exp_seq = cmd_r.seq + SEQ_W'(cmd_r.cnt);
    upd.ts      = cmd_r.ts;
    upd.gaps    = cur.gaps;
    upd.backs   = cur.backs;
    unique case (cmd_r.kind)
      CMD_WRITE: begin
        st = ST_WRITTEN;
      end
      CMD_IGNORE: begin
        st = ST_IGNORED;
      end
      CMD_READ: begin
        st      = ST_REPORT;
        exp_o   = cur.exp_seq;
        prev_o  = cur.ts;
        gaps_o  = cur.gaps;
        backs_o = cur.backs;
      end
      CMD_PACKET: begin
        exp_o  = cur.exp_seq;
        prev_o = cur.ts;
        if (cur.exp_seq == '0) begin
          st = ST_FIRST;
        end else begin
          down_o = cmd_r.ts - cur.ts;
          priority if (cmd_r.seq == cur.exp_seq) begin
            st = ST_IN_ORDER;
          end else if (cmd_r.seq > cur.exp_seq) begin
            st     = ST_GAP;
            lost_o = cmd_r.seq - cur.exp_seq;
            if (cur.gaps != TOT_MAX) begin
              upd.gaps = cur.gaps + TOT_W'(1);
            end
          end else begin
            st = ST_BACK;
            if (cur.backs != TOT_MAX) begin
              upd.backs = cur.backs + TOT_W'(1);
            end
          end
        end
        gaps_o  = upd.gaps;
        backs_o = upd.backs;
      end
      default: begin
        st = ST_IGNORED;
      end
    endcase
  end

  // tracking store: one read port (registered), one write port
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_r <= mem[ra];
    end
    if (fire && cmd_r.kind == CMD_PACKET) begin
      mem[wa] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_v_r <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      if (pop) begin
        rd_v_r <= trk_v_r[ra];
      end
      if (fire && cmd_r.kind == CMD_PACKET) begin
        trk_v_r[wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            cmd_r   <= head;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            st_r        <= st;
            gidx_r      <= IDX_W'(cmd_r.slot);
            exp_r       <= exp_o;
            lost_r      <= lost_o;
            down_r      <= down_o;
            prev_r      <= prev_o;
            gaps_r      <= gaps_o;
            backs_r     <= backs_o;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = st_r;
  assign out_group_index    = gidx_r;
  assign out_expected_seq   = exp_r;
  assign out_lost_count     = lost_r;
  assign out_down_time_ns   = down_r;
  assign out_prev_timestamp = prev_r;
  assign out_gap_total      = gaps_r;
  assign out_back_total     = backs_r;

`ifndef SYNTH
  a_gap_has_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && st_r == ST_GAP) |-> (lost_r != '0))
    else $error("gap word with zero lost count");
  a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && st_r == ST_FIRST) |-> (exp_r == '0 && down_r == '0))
    else $error("first word carries expected or down time");
  a_update_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd_r.kind == CMD_PACKET) |=> trk_v_r[$past(wa)])
    else $error("updated slot not marked tracked");
`endif

endmodule

// ===== hdl/multicast_sequence_gap_tracker_unit.sv =====
// Sequence-gap tracker for MoldUDP64-style multicast groups. Each input word
// is an op: 0 writes a group slot (address, port, valid bit), 1 is a parsed
// packet header, 2 reads back a slot's counters; every word yields exactly one
// result word, in order. A packet matches the lowest valid slot whose address
// and port both equal its destination; non-UDP or unmatched packets come back
// as ignored. The first packet of a group (expected sequence zero) only
// primes it; later ones report in order, gap (lost count, down time) or back
// in time, bump saturating 32-bit counters, and set expected to sequence plus
// message count. The front-end match register holds ready low while it is
// occupied, so a new word is taken only once the last has been handed on; the
// back end runs a read-then-execute pass over the tracking store per word.
// A word passes the match register, the two-entry queue, the back end's read
// and execute states and its output register. All per-group state comes up
// cleared at reset with no sweep: a per-slot tracked bit makes untouched slots
// read as zero, so words are taken the first cycle after reset.
module multicast_sequence_gap_tracker_unit import msgt_pkg::*; #(
  parameter int GROUPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic              in_entry_valid,
  input  logic [ADDR_W-1:0] in_dst_address,
  input  logic [PORT_W-1:0] in_dst_port,
  input  logic              in_is_udp,
  input  logic [SEQ_W-1:0]  in_seq_number,
  input  logic [CNT_W-1:0]  in_msg_count,
  input  logic [TS_W-1:0]   in_timestamp_ns,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   out_status,
  output logic [IDX_W-1:0]  out_group_index,
  output logic [SEQ_W-1:0]  out_expected_seq,
  output logic [SEQ_W-1:0]  out_lost_count,
  output logic [TS_W-1:0]   out_down_time_ns,
  output logic [TS_W-1:0]   out_prev_timestamp,
  output logic [TOT_W-1:0]  out_gap_total,
  output logic [TOT_W-1:0]  out_back_total
);

  // front end -> queue
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // queue -> back end
  logic pop;
  logic q_empty;
  cmd_t head;

  // front end: slot table writes, address/port match, classification
  msgt_front #(
    .GROUPS (GROUPS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_entry_index  (in_entry_index),
    .in_entry_valid  (in_entry_valid),
    .in_dst_address  (in_dst_address),
    .in_dst_port     (in_dst_port),
    .in_is_udp       (in_is_udp),
    .in_seq_number   (in_seq_number),
    .in_msg_count    (in_msg_count),
    .in_timestamp_ns (in_timestamp_ns),
    .push            (push),
    .push_cmd        (push_cmd),
    .q_full          (q_full)
  );

  // two-entry decoupling queue
  msgt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  // back end: tracking store read, classify sequence, write back, output reg
  msgt_back #(
    .GROUPS (GROUPS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_group_index    (out_group_index),
    .out_expected_seq   (out_expected_seq),
    .out_lost_count     (out_lost_count),
    .out_down_time_ns   (out_down_time_ns),
    .out_prev_timestamp (out_prev_timestamp),
    .out_gap_total      (out_gap_total),
    .out_back_total     (out_back_total)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import msgt_pkg::*;

  localparam int GROUPS = 16;
  localparam int RAND_WORDS = 750;
  localparam int FLOWS = 6;
  localparam int CYCLE_LIMIT = 200000;
  // op 3 has no package name; the block must treat it as ignored
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // 233.54.12.72 : 18000, the usual feed group
  localparam logic [ADDR_W-1:0] FEED_ADDR = 32'hE936_0C48;
  localparam logic [PORT_W-1:0] FEED_PORT = 16'd18000;

  // receiver behavior per segment
  localparam int RX_OPEN   = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_HOLD   = 3;

  // one input word, field for field
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic              ev;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic              udp;
    logic [SEQ_W-1:0]  seq;
    logic [CNT_W-1:0]  cnt;
    logic [TS_W-1:0]   ts;
  } hdr_word_t;

  // one result word
  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  group;
    logic [SEQ_W-1:0]  exp_seq;
    logic [SEQ_W-1:0]  lost;
    logic [TS_W-1:0]   down;
    logic [TS_W-1:0]   prev;
    logic [TOT_W-1:0]  gaps;
    logic [TOT_W-1:0]  backs;
  } gap_report_t;

  // directed row: typed=1 means the expected word is written out by hand
  typedef struct {
    hdr_word_t   w;
    bit          typed;
    gap_report_t res;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_op;
  logic [IDX_W-1:0]  in_entry_index;
  logic              in_entry_valid;
  logic [ADDR_W-1:0] in_dst_address;
  logic [PORT_W-1:0] in_dst_port;
  logic              in_is_udp;
  logic [SEQ_W-1:0]  in_seq_number;
  logic [CNT_W-1:0]  in_msg_count;
  logic [TS_W-1:0]   in_timestamp_ns;
  logic              out_valid;
  logic              out_ready;
  logic [ST_W-1:0]   out_status;
  logic [IDX_W-1:0]  out_group_index;
  logic [SEQ_W-1:0]  out_expected_seq;
  logic [SEQ_W-1:0]  out_lost_count;
  logic [TS_W-1:0]   out_down_time_ns;
  logic [TS_W-1:0]   out_prev_timestamp;
  logic [TOT_W-1:0]  out_gap_total;
  logic [TOT_W-1:0]  out_back_total;

  // shadow of the group table and per-group tracking state
  logic [ADDR_W-1:0] tbl_addr  [GROUPS];
  logic [PORT_W-1:0] tbl_port  [GROUPS];
  logic              tbl_valid [GROUPS];
  logic [SEQ_W-1:0]  next_seq  [GROUPS];
  logic [TS_W-1:0]   last_ts   [GROUPS];
  logic [TOT_W-1:0]  gap_tot   [GROUPS];
  logic [TOT_W-1:0]  back_tot  [GROUPS];

  gap_report_t expected_reports[$];
  plan_row_t   plan[$];

  logic [ADDR_W-1:0] flow_addr [FLOWS];
  logic [PORT_W-1:0] flow_port [FLOWS];

  int burst_left = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  multicast_sequence_gap_tracker_unit #(
    .GROUPS(GROUPS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_entry_index     (in_entry_index),
    .in_entry_valid     (in_entry_valid),
    .in_dst_address     (in_dst_address),
    .in_dst_port        (in_dst_port),
    .in_is_udp          (in_is_udp),
    .in_seq_number      (in_seq_number),
    .in_msg_count       (in_msg_count),
    .in_timestamp_ns    (in_timestamp_ns),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_group_index    (out_group_index),
    .out_expected_seq   (out_expected_seq),
    .out_lost_count     (out_lost_count),
    .out_down_time_ns   (out_down_time_ns),
    .out_prev_timestamp (out_prev_timestamp),
    .out_gap_total      (out_gap_total),
    .out_back_total     (out_back_total)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // result word with only status and slot set
  function automatic gap_report_t plain_report(input status_t s, input logic [IDX_W-1:0] g);
    gap_report_t r;
    r = '0;
    r.status = s;
    r.group = g;
    return r;
  endfunction

  // lowest valid slot matching address AND port, -1 if none
  function automatic int match_slot(input logic [ADDR_W-1:0] a, input logic [PORT_W-1:0] p);
    int hit;
    hit = -1;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (tbl_valid[g] && tbl_addr[g] == a && tbl_port[g] == p) hit = g;
    end
    return hit;
  endfunction

  // applies one accepted word to the shadow state, returns the result word
  function automatic gap_report_t classify_word(input hdr_word_t w);
    gap_report_t r;
    int g;
    r = plain_report(ST_IGNORED, '0);
    case (w.op)
      OP_WRITE: if (int'(w.idx) < GROUPS) begin
        // entry only; tracking state survives a rewrite
        tbl_addr[w.idx] = w.addr;
        tbl_port[w.idx] = w.port;
        tbl_valid[w.idx] = w.ev;
        r = plain_report(ST_WRITTEN, w.idx);
      end
      OP_READ: if (int'(w.idx) < GROUPS) begin
        r = plain_report(ST_REPORT, w.idx);
        r.exp_seq = next_seq[w.idx];
        r.prev = last_ts[w.idx];
        r.gaps = gap_tot[w.idx];
        r.backs = back_tot[w.idx];
      end
      OP_PACKET: if (w.udp) begin
        g = match_slot(w.addr, w.port);
        if (g >= 0) begin
          r.group = g[IDX_W-1:0];
          r.exp_seq = next_seq[g];
          r.prev = last_ts[g];
          if (next_seq[g] == '0) begin
            // group not primed yet (or its expected wrapped to zero)
            r.status = ST_FIRST;
          end else begin
            r.down = w.ts - last_ts[g];
            if (w.seq == next_seq[g]) begin
              r.status = ST_IN_ORDER;
            end else if (w.seq > next_seq[g]) begin
              r.status = ST_GAP;
              r.lost = w.seq - next_seq[g];
              if (gap_tot[g] != TOT_MAX) gap_tot[g]++;
            end else begin
              r.status = ST_BACK;
              if (back_tot[g] != TOT_MAX) back_tot[g]++;
            end
          end
          next_seq[g] = w.seq + {{(SEQ_W - CNT_W){1'b0}}, w.cnt};
          last_ts[g] = w.ts;
          r.gaps = gap_tot[g];
          r.backs = back_tot[g];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic hdr_word_t mk_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                        input logic ev, input logic [ADDR_W-1:0] addr,
                                        input logic [PORT_W-1:0] port, input logic udp,
                                        input logic [SEQ_W-1:0] seq, input logic [CNT_W-1:0] cnt,
                                        input logic [TS_W-1:0] ts);
    hdr_word_t w;
    w.op = op;
    w.idx = idx;
    w.ev = ev;
    w.addr = addr;
    w.port = port;
    w.udp = udp;
    w.seq = seq;
    w.cnt = cnt;
    w.ts = ts;
    return w;
  endfunction

  // word with the given op and every other field random
  function automatic hdr_word_t rand_word(input logic [OP_W-1:0] op);
    hdr_word_t w;
    w.op = op;
    w.idx = IDX_W'($urandom);
    w.ev = 1'($urandom);
    w.addr = $urandom;
    w.port = PORT_W'($urandom);
    w.udp = 1'($urandom);
    w.seq = {$urandom, $urandom};
    w.cnt = CNT_W'($urandom);
    w.ts = TS_W'({$urandom, $urandom});
    return w;
  endfunction

  task automatic add_row(input hdr_word_t w, input bit typed, input gap_report_t res);
    plan_row_t row;
    row.w = w;
    row.typed = typed;
    row.res = res;
    plan.push_back(row);
  endtask

  // Offers one word, holding it until accepted, then records what should come
  // back. Called at a rising edge. The sender runs in bursts; valid only drops
  // when a gap is inserted, never between back-to-back words.
  task automatic send_word(input hdr_word_t w, input bit typed, input gap_report_t typed_res);
    int gap;
    gap_report_t pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_op <= w.op;
    in_entry_index <= w.idx;
    in_entry_valid <= w.ev;
    in_dst_address <= w.addr;
    in_dst_port <= w.port;
    in_is_udp <= w.udp;
    in_seq_number <= w.seq;
    in_msg_count <= w.cnt;
    in_timestamp_ns <= w.ts;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // shadow state always advances; hand-typed rows override the prediction
    pred = classify_word(w);
    expected_reports.push_back(typed ? typed_res : pred);
  endtask

  // ---------------------------------------------------------------------------
  // Reset and sender
  // ---------------------------------------------------------------------------

  initial begin : stim
    hdr_word_t w;
    int f;
    int g;
    int k;
    logic [SEQ_W-1:0] base_seq;
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0] base_ts;
    logic [CNT_W-1:0] cnt;
    logic [TS_W-1:0] ts;

    for (int i = 0; i < GROUPS; i++) begin
      tbl_addr[i] = '0;
      tbl_port[i] = '0;
      tbl_valid[i] = 1'b0;
      next_seq[i] = '0;
      last_ts[i] = '0;
      gap_tot[i] = '0;
      back_tot[i] = '0;
    end

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= '0;
    in_entry_index <= '0;
    in_entry_valid <= 1'b0;
    in_dst_address <= '0;
    in_dst_port <= '0;
    in_is_udp <= 1'b0;
    in_seq_number <= '0;
    in_msg_count <= '0;
    in_timestamp_ns <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed table ---
    // counters of untouched slots read back as zero
    add_row(mk_word(OP_READ, 4'd0, 1'b0, '0, '0, 1'b0, '0, '0, '0), 1'b1,
            plain_report(ST_REPORT, 4'd0));
    add_row(mk_word(OP_READ, 4'd15, 1'b1, '1, '1, 1'b1, '1, '1, '1), 1'b1,
            plain_report(ST_REPORT, 4'd15));
    // reset table holds address 0 / port 0 but nothing valid: no match
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, '0, '0, 1'b1, 64'd1, 16'd1, 48'd1), 1'b1,
            plain_report(ST_IGNORED, '0));
    // undefined op
    add_row(mk_word(OP_UNUSED, 4'd15, 1'b1, '1, '1, 1'b1, '1, '1, '1), 1'b1,
            plain_report(ST_IGNORED, '0));
    // entries: all-ones group in slot 0, feed group in 15 and 3
    add_row(mk_word(OP_WRITE, 4'd0, 1'b1, '1, '1, 1'b0, '1, '1, '1), 1'b1,
            plain_report(ST_WRITTEN, 4'd0));
    add_row(mk_word(OP_WRITE, 4'd15, 1'b1, FEED_ADDR, FEED_PORT, 1'b1, '0, '0, '0), 1'b1,
            plain_report(ST_WRITTEN, 4'd15));
    add_row(mk_word(OP_WRITE, 4'd3, 1'b1, FEED_ADDR, FEED_PORT, 1'b0, '0, '0, '0), 1'b1,
            plain_report(ST_WRITTEN, 4'd3));
    // non-UDP on a live group
    add_row(mk_word(OP_PACKET, 4'd3, 1'b1, FEED_ADDR, FEED_PORT, 1'b0, 64'd1000, 16'd5, 48'd9),
            1'b1, plain_report(ST_IGNORED, '0));
    // address hit, port miss / port hit, address miss: AND, not OR
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, FEED_ADDR, FEED_PORT + 16'd1, 1'b1, 64'd3, 16'd1,
                    48'd9), 1'b1, plain_report(ST_IGNORED, '0));
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, '1, FEED_PORT, 1'b1, 64'd3, 16'd1, 48'd9), 1'b1,
            plain_report(ST_IGNORED, '0));
    // feed group lands on slot 3 (lowest): first, in order, gap, back in time
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, FEED_ADDR, FEED_PORT, 1'b1, 64'd1000, 16'd5,
                    48'd100), 1'b0, '0);
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, FEED_ADDR, FEED_PORT, 1'b1, 64'd1005, 16'd5,
                    48'd350), 1'b0, '0);
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, FEED_ADDR, FEED_PORT, 1'b1, 64'd1020, 16'd1,
                    48'd900), 1'b0, '0);
    // timestamp goes backward too: down time wraps mod 2^48
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, FEED_ADDR, FEED_PORT, 1'b1, 64'd1000, 16'd2,
                    48'd40), 1'b0, '0);
    // expected wraps to zero, so the next packet primes again
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, '1, '1, 1'b1, '1, 16'd1, '1), 1'b0, '0);
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, '1, '1, 1'b1, 64'd7, '1, '0), 1'b0, '0);
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, '1, '1, 1'b1, 64'h1_0006, 16'd0, '1), 1'b0, '0);
    // drop slot 3: feed group falls through to slot 15, fresh state
    add_row(mk_word(OP_WRITE, 4'd3, 1'b0, FEED_ADDR, FEED_PORT, 1'b1, '0, '0, '0), 1'b1,
            plain_report(ST_WRITTEN, 4'd3));
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, FEED_ADDR, FEED_PORT, 1'b1, 64'd5, 16'd3, 48'd1),
            1'b0, '0);
    // revive slot 3: its tracking state was kept
    add_row(mk_word(OP_WRITE, 4'd3, 1'b1, FEED_ADDR, FEED_PORT, 1'b0, '0, '0, '0), 1'b1,
            plain_report(ST_WRITTEN, 4'd3));
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, FEED_ADDR, FEED_PORT, 1'b1, 64'd1002, 16'd0,
                    48'd2), 1'b0, '0);
    // seq zero is back in time and leaves expected zero; all-ones then primes and wraps expected
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, FEED_ADDR, FEED_PORT, 1'b1, 64'd0, 16'd0, 48'd3),
            1'b0, '0);
    add_row(mk_word(OP_PACKET, 4'd0, 1'b0, FEED_ADDR, FEED_PORT, 1'b1, '1, 16'd1, 48'd4),
            1'b0, '0);
    add_row(mk_word(OP_READ, 4'd3, 1'b0, '0, '0, 1'b0, '0, '0, '0), 1'b0, '0);
    add_row(mk_word(OP_READ, 4'd15, 1'b0, '0, '0, 1'b0, '0, '0, '0), 1'b0, '0);
    add_row(mk_word(OP_READ, 4'd0, 1'b0, '0, '0, 1'b0, '0, '0, '0), 1'b0, '0);

    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].res);

    // --- random part ---
    // a handful of live flows on distinct slots, then mostly well-formed
    // traffic on them with gaps, reorders, rewrites, reads and noise mixed in
    k = $urandom_range(0, 15);
    for (int i = 0; i < FLOWS; i++) begin
      flow_addr[i] = $urandom;
      flow_port[i] = PORT_W'($urandom);
      w = mk_word(OP_WRITE, IDX_W'((k + i * 5) % GROUPS), 1'b1, flow_addr[i], flow_port[i],
                  1'($urandom_range(0, 1)), {$urandom, $urandom}, CNT_W'($urandom),
                  TS_W'({$urandom, $urandom}));
      send_word(w, 1'b0, '0);
    end

    for (int n = 0; n < RAND_WORDS; n++) begin
      f = $urandom_range(0, FLOWS - 1);
      k = $urandom_range(0, 99);
      if (k < 75) begin
        g = match_slot(flow_addr[f], flow_port[f]);
        base_seq = (g >= 0) ? next_seq[g] : '0;
        base_ts = (g >= 0) ? last_ts[g] : '0;
        k = $urandom_range(0, 99);
        if (base_seq == '0 || k < 8) begin
          seq = {$urandom, $urandom};
        end else if (k < 70) begin
          seq = base_seq;
        end else if (k < 85) begin
          seq = base_seq + SEQ_W'($urandom_range(1, 500));
        end else begin
          seq = base_seq - SEQ_W'($urandom_range(1, 500));
        end
        cnt = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(1, 20));
        ts = ($urandom_range(0, 9) == 0) ? TS_W'({$urandom, $urandom})
                                         : base_ts + TS_W'($urandom_range(0, 5000));
        // a few go out as non-UDP on a live flow
        w = mk_word(OP_PACKET, IDX_W'($urandom), 1'($urandom), flow_addr[f], flow_port[f],
                    $urandom_range(0, 14) != 0, seq, cnt, ts);
      end else if (k < 81) begin
        // (re)point a slot at a flow, now and then disabled
        w = mk_word(OP_WRITE, IDX_W'($urandom), $urandom_range(0, 5) != 0, flow_addr[f],
                    flow_port[f], 1'($urandom), {$urandom, $urandom}, CNT_W'($urandom),
                    TS_W'({$urandom, $urandom}));
      end else if (k < 84) begin
        w = rand_word(OP_WRITE);
      end else if (k < 92) begin
        w = rand_word(OP_READ);
      end else if (k < 97) begin
        // stray packet, almost surely unmatched
        w = rand_word(OP_PACKET);
      end else begin
        w = rand_word(OP_UNUSED);
      end
      send_word(w, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then a short tail to catch any stray word
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: segments of open, random and sparse ready, plus a long hold-off
  // now and then so the block backs up and drops in_ready.
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    int seg;
    int len;
    int mode;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    seg = 0;
    forever begin
      mode = (seg % 20 == 3) ? RX_HOLD : $urandom_range(RX_OPEN, RX_SPARSE);
      len = (mode == RX_HOLD) ? 120 : $urandom_range(10, 150);
      for (int i = 0; i < len; i++) begin
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_RANDOM: out_ready <= $urandom_range(0, 1);
          RX_SPARSE: out_ready <= (i % 4 == 0);
          default:   out_ready <= 1'b0;
        endcase
        @(posedge clk);
      end
      seg++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin : result_check
    gap_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result word, status %0d group %0d", $time, out_status,
                 out_group_index);
        mismatch_cnt++;
      end else begin
        want = expected_reports.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("group_index", 64'(want.group), 64'(out_group_index));
        check_field("expected_seq", want.exp_seq, out_expected_seq);
        check_field("lost_count", want.lost, out_lost_count);
        check_field("down_time_ns", 64'(want.down), 64'(out_down_time_ns));
        check_field("prev_timestamp", 64'(want.prev), 64'(out_prev_timestamp));
        check_field("gap_total", 64'(want.gaps), 64'(out_gap_total));
        check_field("back_total", 64'(want.backs), 64'(out_back_total));
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hdl/msgt_pkg.sv
hdl/msgt_front.sv
hdl/msgt_queue.sv
hdl/msgt_back.sv
hdl/multicast_sequence_gap_tracker_unit.sv
dv/tb_top.sv
